### design/gcd_pkg.sv
package gcd_pkg;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 31;
  localparam int unsigned LANES        = 4;

  // pipeline stage numbers (1-based, count of registers from the input)
  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned A_STAGE      = FRONT_STAGES + CORDIC_STEPS + 5;
  localparam int unsigned ROOT_STAGE   = A_STAGE + SQRT_STEPS + 1;
  localparam int unsigned NUM_STAGES   = ROOT_STAGE + CORDIC_STEPS + 2;

  localparam logic signed [33:0] TURN_HALF_UNITS = 34'sd7200000000;
  localparam logic signed [33:0] HALF_TURN       = 34'sd3600000000;
  localparam logic signed [33:0] NEG_HALF_TURN   = -34'sd3600000000;
  localparam logic signed [33:0] QUARTER_TURN    = 34'sd1800000000;
  localparam logic signed [33:0] NEG_QUARTER     = -34'sd1800000000;

  localparam logic [30:0]        HALF_UNIT_TO_Q29 = 31'd2012227627;
  localparam logic signed [31:0] CORDIC_GAIN_Q30  = 32'sd652032874;
  localparam logic [30:0]        Q30_ONE          = 31'h4000_0000;
  localparam logic [23:0]        EARTH_DIAMETER_M = 24'd12742000;
  localparam logic [24:0]        MAX_DISTANCE_M   = 25'd20015087;

  // atan(2^-i) in q3.29
  function automatic logic signed [31:0] atan_step(input int unsigned i);
    logic signed [31:0] v;
    unique case (i)
      0:       v = 32'sd421657428;
      1:       v = 32'sd248918915;
      2:       v = 32'sd131521918;
      3:       v = 32'sd66762579;
      4:       v = 32'sd33510843;
      5:       v = 32'sd16771758;
      6:       v = 32'sd8387925;
      7:       v = 32'sd4194219;
      8:       v = 32'sd2097141;
      9:       v = 32'sd1048575;
      default: v = 32'(32'sd1 <<< (29 - i));
    endcase
    return v;
  endfunction

endpackage

### design/great_circle_distance.sv
// great-circle (haversine) distance engine
//
// input channel: two positions (from_lat/from_lon, to_lat/to_lon) in signed
// units of 1e-7 degree, one beat per pair, in_valid_i / in_ready_o
// output channel: distance_m_o in whole meters, out_valid_o / out_ready_i
//
// fully pipelined: 104 register stages, one pair enters every cycle while the
// pipeline is not stalled. the depth is set by the two 30-step cordic
// chains (sin/cos rotation, atan2 vectoring) and the 31-step square root,
// one step per stage.
//
// the whole pipeline advances together; when the receiver holds out_ready_i
// low while a result waits, every stage freezes and in_ready_o drops, so no
// beat is lost or repeated. throughput is one beat per cycle when unstalled.
//
// reset clears the stage valid bits only; the pipeline is empty afterwards.
module great_circle_distance
  import gcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] from_lat_i,
  input  logic signed [31:0] from_lon_i,
  input  logic signed [30:0] to_lat_i,
  input  logic signed [31:0] to_lon_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [24:0]        distance_m_o
);

  logic                  en;
  logic [NUM_STAGES-1:0] v_q;

  // global advance: last stage empty or being taken
  assign en          = !v_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // front: angle differences, wrap, fold, convert to q3.29
  // lanes: 0 dlat, 1 dlon, 2 2*lat1, 3 2*lat2 (units of 0.5e-7 degree)
  // ---------------------------------------------------------------------
  logic signed [33:0] ang1_q [LANES];
  logic signed [33:0] m2_q   [LANES];
  logic [30:0]        mag3_q [LANES];
  logic               neg3_q [LANES];
  logic               flip3_q[LANES];
  logic [61:0]        prod4_q[LANES];
  logic               neg4_q [LANES];
  logic               flip4_q[LANES];
  logic signed [31:0] z5_q   [LANES];
  logic               flip5_q[LANES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang1_q[0] <= 34'(to_lat_i) - 34'(from_lat_i);
      ang1_q[1] <= 34'(to_lon_i) - 34'(from_lon_i);
      ang1_q[2] <= 34'(from_lat_i) + 34'(from_lat_i);
      ang1_q[3] <= 34'(to_lat_i) + 34'(to_lat_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        // wrap to (-180, 180] degrees
        if (ang1_q[l] > HALF_TURN) begin
          m2_q[l] <= ang1_q[l] - TURN_HALF_UNITS;
        end else if (ang1_q[l] <= NEG_HALF_TURN) begin
          m2_q[l] <= ang1_q[l] + TURN_HALF_UNITS;
        end else begin
          m2_q[l] <= ang1_q[l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        logic signed [33:0] f;
        logic               fl;
        // fold into [-90, 90] degrees, cosine sign flips
        if (m2_q[l] > QUARTER_TURN) begin
          f  = HALF_TURN - m2_q[l];
          fl = 1'b1;
        end else if (m2_q[l] < NEG_QUARTER) begin
          f  = NEG_HALF_TURN - m2_q[l];
          fl = 1'b1;
        end else begin
          f  = m2_q[l];
          fl = 1'b0;
        end
        neg3_q[l]  <= f[33];
        mag3_q[l]  <= f[33] ? 31'(-f) : f[30:0];
        flip3_q[l] <= fl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        prod4_q[l] <= 62'(mag3_q[l]) * 62'(HALF_UNIT_TO_Q29);
        neg4_q[l]  <= neg3_q[l];
        flip4_q[l] <= flip3_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        logic [62:0] rs;
        logic [31:0] r;
        rs = 63'(prod4_q[l]) + (63'd1 << 31);
        r  = {1'b0, rs[62:32]};
        z5_q[l]    <= neg4_q[l] ? -signed'(r) : signed'(r);
        flip5_q[l] <= flip4_q[l];
      end
    end
  end

  // ---------------------------------------------------------------------
  // rotation cordic, one step per stage
  // ---------------------------------------------------------------------
  logic signed [31:0] rx_q [CORDIC_STEPS][LANES];
  logic signed [31:0] ry_q [CORDIC_STEPS][LANES];
  logic signed [31:0] rz_q [CORDIC_STEPS][LANES];
  logic               rf_q [CORDIC_STEPS][LANES];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    logic signed [31:0] xi [LANES];
    logic signed [31:0] yi [LANES];
    logic signed [31:0] zi [LANES];
    logic               fi [LANES];

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          xi[l] = CORDIC_GAIN_Q30;
          yi[l] = '0;
          zi[l] = z5_q[l];
          fi[l] = flip5_q[l];
        end
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          xi[l] = rx_q[g-1][l];
          yi[l] = ry_q[g-1][l];
          zi[l] = rz_q[g-1][l];
          fi[l] = rf_q[g-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (zi[l] >= 0) begin
            rx_q[g][l] <= xi[l] - (yi[l] >>> g);
            ry_q[g][l] <= yi[l] + (xi[l] >>> g);
            rz_q[g][l] <= zi[l] - atan_step(g);
          end else begin
            rx_q[g][l] <= xi[l] + (yi[l] >>> g);
            ry_q[g][l] <= yi[l] - (xi[l] >>> g);
            rz_q[g][l] <= zi[l] + atan_step(g);
          end
          rf_q[g][l] <= fi[l];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // a = sin^2(dlat/2) + cos1*cos2*sin^2(dlon/2), q1.30
  // ---------------------------------------------------------------------
  logic signed [63:0] psl_q, psn_q, pcc_q;
  logic signed [31:0] sql2_q, sqn2_q, cc2_q;
  logic signed [63:0] m3_q;
  logic signed [31:0] sql3_q;
  logic signed [32:0] a4_q;
  logic [30:0]        a5_q;
  logic [61:0]        n5_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [31:0] c1, c2;
      c1 = rf_q[CORDIC_STEPS-1][2] ? -rx_q[CORDIC_STEPS-1][2] : rx_q[CORDIC_STEPS-1][2];
      c2 = rf_q[CORDIC_STEPS-1][3] ? -rx_q[CORDIC_STEPS-1][3] : rx_q[CORDIC_STEPS-1][3];
      psl_q <= 64'(ry_q[CORDIC_STEPS-1][0]) * 64'(ry_q[CORDIC_STEPS-1][0]);
      psn_q <= 64'(ry_q[CORDIC_STEPS-1][1]) * 64'(ry_q[CORDIC_STEPS-1][1]);
      pcc_q <= 64'(c1) * 64'(c2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [63:0] tl, tn, tc;
      tl = psl_q + 64'sd536870912;
      tn = psn_q + 64'sd536870912;
      tc = pcc_q + 64'sd536870912;
      sql2_q <= tl[61:30];
      sqn2_q <= tn[61:30];
      cc2_q  <= tc[61:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_q   <= 64'(cc2_q) * 64'(sqn2_q);
      sql3_q <= sql2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [63:0] t;
      t = m3_q + 64'sd536870912;
      a4_q <= 33'(signed'(t[61:30])) + 33'(sql3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [30:0] ac;
      if (a4_q[32]) begin
        ac = '0;
      end else if (a4_q[31:0] > 32'(Q30_ONE)) begin
        ac = Q30_ONE;
      end else begin
        ac = a4_q[30:0];
      end
      a5_q    <= ac;
      n5_q[0] <= 62'(ac) << 30;
      n5_q[1] <= 62'(Q30_ONE - ac) << 30;
    end
  end

  // ---------------------------------------------------------------------
  // square roots of a and 1-a, one result bit per stage
  // lane 0 sqrt(a), lane 1 sqrt(1-a)
  // ---------------------------------------------------------------------
  logic [61:0] sn_q [SQRT_STEPS][2];
  logic [61:0] sr_q [SQRT_STEPS][2];
  logic [30:0] root_q [2];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    localparam logic [61:0] Bit = 62'd1 << (2 * (SQRT_STEPS - 1 - g));
    logic [61:0] ni [2];
    logic [61:0] ri [2];

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          ni[l] = n5_q[l];
          ri[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          ni[l] = sn_q[g-1][l];
          ri[l] = sr_q[g-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (ni[l] >= ri[l] + Bit) begin
            sn_q[g][l] <= ni[l] - (ri[l] + Bit);
            sr_q[g][l] <= (ri[l] >> 1) + Bit;
          end else begin
            sn_q[g][l] <= ni[l];
            sr_q[g][l] <= ri[l] >> 1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        // round to nearest
        root_q[l] <= 31'(sr_q[SQRT_STEPS-1][l] +
                         62'(sn_q[SQRT_STEPS-1][l] > sr_q[SQRT_STEPS-1][l]));
      end
    end
  end

  // ---------------------------------------------------------------------
  // vectoring cordic: atan2(sqrt(a), sqrt(1-a)) in q3.29
  // ---------------------------------------------------------------------
  logic signed [32:0] vx_q [CORDIC_STEPS];
  logic signed [32:0] vy_q [CORDIC_STEPS];
  logic signed [31:0] vz_q [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    logic signed [32:0] xi, yi;
    logic signed [31:0] zi;

    if (g == 0) begin : g_first
      assign xi = signed'(33'(root_q[1]));
      assign yi = signed'(33'(root_q[0]));
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_q[g-1];
      assign yi = vy_q[g-1];
      assign zi = vz_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (yi >= 0) begin
          vx_q[g] <= xi + (yi >>> g);
          vy_q[g] <= yi - (xi >>> g);
          vz_q[g] <= zi + atan_step(g);
        end else begin
          vx_q[g] <= xi - (yi >>> g);
          vy_q[g] <= yi + (xi >>> g);
          vz_q[g] <= zi - atan_step(g);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // scale by earth diameter, round, saturate
  // ---------------------------------------------------------------------
  logic [54:0] dp_q;
  logic [24:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [30:0] zc;
      zc   = vz_q[CORDIC_STEPS-1][31] ? '0 : vz_q[CORDIC_STEPS-1][30:0];
      dp_q <= 55'(zc) * 55'(EARTH_DIAMETER_M);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [55:0] t;
      logic [26:0] d;
      t = 56'(dp_q) + (56'd1 << 28);
      d = t[55:29];
      dist_q <= (d > 27'(MAX_DISTANCE_M)) ? MAX_DISTANCE_M : d[24:0];
    end
  end

  assign distance_m_o = dist_q;

`ifndef NO_ASSERTIONS
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(v_q))
    else $error("stage valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted beat did not enter the pipeline");

  a_a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[A_STAGE-1] |-> a5_q <= Q30_ONE)
    else $error("haversine term a out of range");

  a_dist_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_m_o <= MAX_DISTANCE_M)
    else $error("distance above half circumference");
`endif

endmodule
